### design/rgbrle_pkg.sv
`default_nettype none

package rgbrle_pkg;

  localparam int unsigned MaxBlockDef     = 128;
  localparam int unsigned WordsPerBeatDef = 4;
  localparam int unsigned PixW            = 16;
  localparam int unsigned InW             = 24;
  localparam int unsigned BeatWords       = 4;

  localparam logic [1:0] KindLitHdr  = 2'd0;
  localparam logic [1:0] KindRun     = 2'd1;
  localparam logic [1:0] KindLitBeat = 2'd2;

  localparam logic [7:0] RunFlag    = 8'h80;
  localparam logic [7:0] RunLenMask = 8'h7f;

  typedef struct packed {
    logic [1:0]                      kind;
    logic [7:0]                      hdr;
    logic [2:0]                      cnt;
    logic [BeatWords-1:0][PixW-1:0]  words;
  } rec_t;

  function automatic logic [PixW-1:0] to_rgb565(input logic [InW-1:0] c, input logic fmt);
    logic [PixW-1:0] p;
    if (fmt) begin
      p = {c[23:19], c[15:10], c[7:3]};
    end else begin
      p = c[PixW-1:0];
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### design/rgbrle_lit_store.sv
`default_nettype none

module rgbrle_lit_store #(
  parameter int unsigned Depth = rgbrle_pkg::MaxBlockDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic [AddrW-1:0]            wr_addr_i,
  input  wire logic [rgbrle_pkg::PixW-1:0] wr_data_i,
  input  wire logic                        rd_en_i,
  input  wire logic [AddrW-1:0]            rd_addr_i,
  output      logic [rgbrle_pkg::PixW-1:0] rd_data_o
);
  import rgbrle_pkg::*;

  logic [PixW-1:0] mem [Depth];
  logic [PixW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### design/rgb565_run_length_encoder.sv
// PackBits-style run-length encoder for a stream of RGB565 pixels.
// Input channel: pixel_i with last_pixel_i, handshake in_valid_i / in_stall_o.
// Output channel: one record per transaction (literal header, run record or
// literal data beat of up to WORDS_PER_BEAT words), handshake out_valid_o /
// out_stall_i; end_of_stream_o marks the final record of an image.
// cfg_wr_en_i / cfg_wr_data_i select the pixel format (0 RGB565, 1 BGR888);
// write it only while the encoder is idle.
// One pixel at a time: a small sequencer drives a single 16-bit equality
// comparator and a literal store with separate write and read ports. A pixel
// that emits nothing holds in_stall_o high after acceptance through the
// evaluate, post and finish states; lookahead checks and a run record add
// further states. A literal flush takes a header step, then a store read
// and a capture step per word and a push step per beat.
// The last pixel drains lookahead, run and literal store, writing each
// lookahead word to the store before the flush.
// Records leave through a staging register and an output register; a pixel's
// last record turns valid in the cycle in_stall_o falls. While the receiver
// stalls, the sequencer holds at its next record and the output register
// keeps its payload. Reset clears all control state and the format register;
// the literal store needs no clearing.
`default_nettype none

module rgb565_run_length_encoder #(
  parameter int unsigned MAX_BLOCK      = rgbrle_pkg::MaxBlockDef,
  parameter int unsigned WORDS_PER_BEAT = rgbrle_pkg::WordsPerBeatDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_wr_en_i,
  input  wire logic                        cfg_wr_data_i,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [rgbrle_pkg::InW-1:0]  pixel_i,
  input  wire logic                        last_pixel_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [1:0]                  record_kind_o,
  output      logic [7:0]                  header_byte_o,
  output      logic [2:0]                  word_count_o,
  output      logic [rgbrle_pkg::PixW-1:0] word_a_o,
  output      logic [rgbrle_pkg::PixW-1:0] word_b_o,
  output      logic [rgbrle_pkg::PixW-1:0] word_c_o,
  output      logic [rgbrle_pkg::PixW-1:0] word_d_o,
  output      logic                        end_of_stream_o
);
  import rgbrle_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_BLOCK + 1);
  localparam int unsigned IdxW = $clog2(MAX_BLOCK);
  localparam int unsigned NW   = $clog2(WORDS_PER_BEAT + 1);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StEval  = 4'd1;
  localparam logic [3:0] StCheck = 4'd2;
  localparam logic [3:0] StAdd2  = 4'd3;
  localparam logic [3:0] StPost  = 4'd4;
  localparam logic [3:0] StRun   = 4'd5;
  localparam logic [3:0] StDrain = 4'd6;
  localparam logic [3:0] StHdr   = 4'd7;
  localparam logic [3:0] StRd    = 4'd8;
  localparam logic [3:0] StCap   = 4'd9;
  localparam logic [3:0] StPushB = 4'd10;
  localparam logic [3:0] StFin   = 4'd11;

  logic [3:0] state_q, state_d, ret_q, ret_d;
  logic       fmt_q;
  logic       last_q, last_d;
  logic       eq_q, eq_d;
  logic       drain_q, drain_d;
  logic       in_run_q, in_run_d;
  logic [1:0] la_cnt_q, la_cnt_d, di_q, di_d, la_idx;
  logic [CntW-1:0] run_len_q, run_len_d, lit_cnt_q, lit_cnt_d, pos_q, pos_d;
  logic [NW-1:0]   n_q, n_d;
  logic [PixW-1:0] p_q, p_d;
  logic [2:0][PixW-1:0] la_q, la_d;
  logic [WORDS_PER_BEAT-1:0][PixW-1:0] beat_q, beat_d;

  logic stage_v_q, stage_v_d, out_v_q, out_v_d, out_eos_q, out_eos_d;
  rec_t stage_q, stage_d, out_q, out_d, push_rec;
  logic push, fin_mv, mv_ok, push_ok;

  logic [PixW-1:0] cmp_a, cmp_b, wr_data, rd_data;
  logic            eq, lit_full, wr_en, rd_en;

  rgbrle_lit_store #(
    .Depth (MAX_BLOCK),
    .AddrW (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (lit_cnt_q[IdxW-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (pos_q[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  always_comb begin
    cmp_a = p_q;
    cmp_b = la_q[0];
    if (state_q == StEval && !in_run_q) begin
      cmp_b = la_q[1];
    end
    if (state_q == StCheck) begin
      cmp_a = la_q[0];
      cmp_b = la_q[1];
    end
  end

  assign eq       = (cmp_a == cmp_b);
  assign lit_full = (lit_cnt_q == CntW'(MAX_BLOCK - 1));
  assign la_idx   = (la_cnt_q > 2'd2) ? 2'd2 : la_cnt_q;
  assign mv_ok    = !out_v_q || !out_stall_i;
  assign push_ok  = !stage_v_q || mv_ok;

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    last_d    = last_q;
    eq_d      = eq_q;
    drain_d   = drain_q;
    in_run_d  = in_run_q;
    la_cnt_d  = la_cnt_q;
    di_d      = di_q;
    run_len_d = run_len_q;
    lit_cnt_d = lit_cnt_q;
    pos_d     = pos_q;
    n_d       = n_q;
    p_d       = p_q;
    la_d      = la_q;
    beat_d    = beat_q;
    wr_en     = 1'b0;
    wr_data   = la_q[0];
    rd_en     = 1'b0;
    push      = 1'b0;
    push_rec  = '0;
    fin_mv    = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          p_d     = to_rgb565(pixel_i, fmt_q);
          last_d  = last_pixel_i;
          state_d = StEval;
        end
      end
      StEval: begin
        eq_d = eq;
        if (in_run_q) begin
          if (eq) begin
            run_len_d = run_len_q + CntW'(1);
            state_d   = (run_len_q >= CntW'(MAX_BLOCK - 1)) ? StRun : StPost;
          end else begin
            state_d = StRun;
          end
        end else begin
          la_d[la_idx] = p_q;
          la_cnt_d     = la_idx + 2'd1;
          state_d      = (la_idx == 2'd2) ? StCheck : StPost;
        end
      end
      StCheck: begin
        if (eq && eq_q) begin
          in_run_d  = 1'b1;
          run_len_d = CntW'(3);
          ret_d     = StPost;
          state_d   = (lit_cnt_q != '0) ? StHdr : StPost;
        end else begin
          wr_en     = 1'b1;
          wr_data   = la_q[0];
          lit_cnt_d = lit_cnt_q + CntW'(1);
          ret_d     = StAdd2;
          state_d   = lit_full ? StHdr : StAdd2;
        end
      end
      StAdd2: begin
        la_d[0] = la_q[2];
        if (eq_q) begin
          la_cnt_d = 2'd2;
          state_d  = StPost;
        end else begin
          wr_en     = 1'b1;
          wr_data   = la_q[1];
          lit_cnt_d = lit_cnt_q + CntW'(1);
          la_cnt_d  = 2'd1;
          ret_d     = StPost;
          state_d   = lit_full ? StHdr : StPost;
        end
      end
      StPost: begin
        if (last_q && !drain_q) begin
          drain_d = 1'b1;
          di_d    = 2'd0;
          state_d = in_run_q ? StRun : StDrain;
        end else begin
          state_d = StFin;
        end
      end
      StRun: begin
        if (push_ok) begin
          push              = 1'b1;
          push_rec.kind     = KindRun;
          push_rec.hdr      = (8'(run_len_q - CntW'(1)) & RunLenMask) | RunFlag;
          push_rec.cnt      = 3'd1;
          push_rec.words[0] = la_q[0];
          in_run_d          = 1'b0;
          run_len_d         = '0;
          if (eq_q) begin
            la_cnt_d = 2'd0;
          end else begin
            la_d[0]  = p_q;
            la_cnt_d = 2'd1;
          end
          state_d = drain_q ? StFin : StPost;
        end
      end
      StDrain: begin
        if (di_q < la_cnt_q) begin
          wr_en     = 1'b1;
          wr_data   = la_q[di_q];
          lit_cnt_d = lit_cnt_q + CntW'(1);
          di_d      = di_q + 2'd1;
          ret_d     = StDrain;
          if (lit_full) begin
            state_d = StHdr;
          end
        end else begin
          ret_d   = StFin;
          state_d = (lit_cnt_q != '0) ? StHdr : StFin;
        end
      end
      StHdr: begin
        if (push_ok) begin
          push          = 1'b1;
          push_rec.kind = KindLitHdr;
          push_rec.hdr  = 8'(lit_cnt_q - CntW'(1));
          pos_d         = '0;
          n_d           = '0;
          beat_d        = '0;
          state_d       = StRd;
        end
      end
      StRd: begin
        rd_en   = 1'b1;
        state_d = StCap;
      end
      StCap: begin
        for (int k = 0; k < WORDS_PER_BEAT; k++) begin
          if (n_q == NW'(k)) begin
            beat_d[k] = rd_data;
          end
        end
        n_d   = n_q + NW'(1);
        pos_d = pos_q + CntW'(1);
        if (n_q == NW'(WORDS_PER_BEAT - 1) || (pos_q + CntW'(1)) == lit_cnt_q) begin
          state_d = StPushB;
        end else begin
          state_d = StRd;
        end
      end
      StPushB: begin
        if (push_ok) begin
          push          = 1'b1;
          push_rec.kind = KindLitBeat;
          push_rec.cnt  = 3'(n_q);
          for (int k = 0; k < WORDS_PER_BEAT; k++) begin
            push_rec.words[k] = beat_q[k];
          end
          n_d    = '0;
          beat_d = '0;
          if (pos_q == lit_cnt_q) begin
            lit_cnt_d = '0;
            state_d   = ret_q;
          end else begin
            state_d = StRd;
          end
        end
      end
      StFin: begin
        if (push_ok) begin
          fin_mv  = stage_v_q;
          drain_d = 1'b0;
          if (last_q) begin
            la_cnt_d  = 2'd0;
            in_run_d  = 1'b0;
            run_len_d = '0;
            lit_cnt_d = '0;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    stage_v_d = stage_v_q;
    stage_d   = stage_q;
    out_v_d   = out_v_q && out_stall_i;
    out_d     = out_q;
    out_eos_d = out_eos_q;
    if (push) begin
      if (stage_v_q) begin
        out_v_d   = 1'b1;
        out_d     = stage_q;
        out_eos_d = 1'b0;
      end
      stage_d   = push_rec;
      stage_v_d = 1'b1;
    end else if (fin_mv) begin
      out_v_d   = 1'b1;
      out_d     = stage_q;
      out_eos_d = last_q;
      stage_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      ret_q     <= StIdle;
      fmt_q     <= 1'b0;
      last_q    <= 1'b0;
      drain_q   <= 1'b0;
      in_run_q  <= 1'b0;
      la_cnt_q  <= 2'd0;
      di_q      <= 2'd0;
      run_len_q <= '0;
      lit_cnt_q <= '0;
      pos_q     <= '0;
      n_q       <= '0;
      stage_v_q <= 1'b0;
      out_v_q   <= 1'b0;
      out_eos_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      if (cfg_wr_en_i) begin
        fmt_q <= cfg_wr_data_i;
      end
      last_q    <= last_d;
      drain_q   <= drain_d;
      in_run_q  <= in_run_d;
      la_cnt_q  <= la_cnt_d;
      di_q      <= di_d;
      run_len_q <= run_len_d;
      lit_cnt_q <= lit_cnt_d;
      pos_q     <= pos_d;
      n_q       <= n_d;
      stage_v_q <= stage_v_d;
      out_v_q   <= out_v_d;
      out_eos_q <= out_eos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    eq_q    <= eq_d;
    la_q    <= la_d;
    beat_q  <= beat_d;
    stage_q <= stage_d;
    out_q   <= out_d;
  end

  assign in_stall_o      = (state_q != StIdle);
  assign out_valid_o     = out_v_q;
  assign record_kind_o   = out_q.kind;
  assign header_byte_o   = out_q.hdr;
  assign word_count_o    = out_q.cnt;
  assign word_a_o        = out_q.words[0];
  assign word_b_o        = out_q.words[1];
  assign word_c_o        = out_q.words[2];
  assign word_d_o        = out_q.words[3];
  assign end_of_stream_o = out_eos_q;

`ifndef SYNTHESIS
  a_lit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lit_cnt_q <= CntW'(MAX_BLOCK))
    else $error("literal count above block size");

  a_run_lookahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_run_q |-> la_cnt_q == 2'd3)
    else $error("run active without full lookahead");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> !stage_v_q)
    else $error("staged record left behind at idle");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRd |-> pos_q < lit_cnt_q)
    else $error("literal read beyond fill count");

  a_run_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o == KindRun |-> header_byte_o[7] && word_count_o == 3'd1)
    else $error("malformed run record");
`endif

endmodule

`default_nettype wire

### dv/rgb565_run_length_encoder_tb.sv
module rgb565_run_length_encoder_tb;
  import rgbrle_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned DrainCycles   = 50;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      hdr;
    logic [2:0]      cnt;
    logic [PixW-1:0] word_a;
    logic [PixW-1:0] word_b;
    logic [PixW-1:0] word_c;
    logic [PixW-1:0] word_d;
    logic            eos;
  } enc_record_t;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            cfg_wr_en_i   = 1'b0;
  logic            cfg_wr_data_i = 1'b0;
  logic            in_valid_i    = 1'b0;
  logic            in_stall_o;
  logic [InW-1:0]  pixel_i       = '0;
  logic            last_pixel_i  = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i   = 1'b0;
  logic [1:0]      record_kind_o;
  logic [7:0]      header_byte_o;
  logic [2:0]      word_count_o;
  logic [PixW-1:0] word_a_o;
  logic [PixW-1:0] word_b_o;
  logic [PixW-1:0] word_c_o;
  logic [PixW-1:0] word_d_o;
  logic            end_of_stream_o;

  rgb565_run_length_encoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_i        (pixel_i),
    .last_pixel_i   (last_pixel_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .record_kind_o  (record_kind_o),
    .header_byte_o  (header_byte_o),
    .word_count_o   (word_count_o),
    .word_a_o       (word_a_o),
    .word_b_o       (word_b_o),
    .word_c_o       (word_c_o),
    .word_d_o       (word_d_o),
    .end_of_stream_o(end_of_stream_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Encoder model state
  logic [PixW-1:0] la_word [3]   = '{default: '0};
  int unsigned     la_count      = 0;
  bit              in_run        = 1'b0;
  int unsigned     run_len       = 0;
  logic [PixW-1:0] lit_word [MaxBlockDef];
  int unsigned     lit_count     = 0;
  bit              pix_fmt       = 1'b0;

  enc_record_t     expected_records [$];
  int unsigned     mismatch_count = 0;
  int unsigned     idle_cycles    = 0;
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_idle_pct  = 0;
  logic            hold_start     = 1'b0;
  int unsigned     hold_left      = 0;

  function automatic void push_record(input logic [1:0] kind, input logic [7:0] hdr,
                                      input logic [2:0] cnt,
                                      input logic [BeatWords-1:0][PixW-1:0] words);
    enc_record_t r;
    r.kind   = kind;
    r.hdr    = hdr;
    r.cnt    = cnt;
    r.word_a = words[0];
    r.word_b = words[1];
    r.word_c = words[2];
    r.word_d = words[3];
    r.eos    = 1'b0;
    expected_records.push_back(r);
  endfunction

  function automatic void flush_literals();
    logic [BeatWords-1:0][PixW-1:0] words;
    int unsigned pos;
    int unsigned n;
    if (lit_count == 0) return;
    push_record(KindLitHdr, 8'(lit_count - 1), 3'd0, '0);
    pos = 0;
    while (pos < lit_count) begin
      words = '0;
      n = 0;
      while (n < BeatWords && pos < lit_count) begin
        words[n] = lit_word[pos];
        n++;
        pos++;
      end
      push_record(KindLitBeat, 8'd0, 3'(n), words);
    end
    lit_count = 0;
  endfunction

  function automatic void add_literal(input logic [PixW-1:0] w);
    lit_word[lit_count] = w;
    lit_count++;
    if (lit_count >= MaxBlockDef) flush_literals();
  endfunction

  function automatic void emit_run();
    logic [BeatWords-1:0][PixW-1:0] words;
    words    = '0;
    words[0] = la_word[0];
    push_record(KindRun, (8'(run_len - 1) & RunLenMask) | RunFlag, 3'd1, words);
    in_run  = 1'b0;
    run_len = 0;
  endfunction

  function automatic void encode_pixel(input logic [InW-1:0] px, input logic last);
    logic [PixW-1:0] p;
    int unsigned     first_new;
    int unsigned     i;
    first_new = expected_records.size();
    p = pix_fmt ? {px[23:19], px[15:10], px[7:3]} : px[PixW-1:0];
    if (in_run) begin
      if (p == la_word[0]) begin
        run_len++;
        if (run_len >= MaxBlockDef) begin
          emit_run();
          la_count = 0;
        end
      end else begin
        emit_run();
        la_word[0] = p;
        la_count   = 1;
      end
    end else begin
      if (la_count > 2) la_count = 2;
      la_word[la_count] = p;
      la_count++;
      if (la_count == 3) begin
        if (la_word[0] == la_word[1] && la_word[1] == la_word[2]) begin
          flush_literals();
          in_run  = 1'b1;
          run_len = 3;
        end else begin
          add_literal(la_word[0]);
          if (la_word[1] == la_word[2]) begin
            la_word[0] = la_word[2];
            la_count   = 2;
          end else begin
            add_literal(la_word[1]);
            la_word[0] = la_word[2];
            la_count   = 1;
          end
        end
      end
    end
    if (last) begin
      if (in_run) begin
        emit_run();
      end else begin
        for (i = 0; i < la_count && i < 3; i++) add_literal(la_word[i]);
        flush_literals();
      end
      la_count  = 0;
      in_run    = 1'b0;
      run_len   = 0;
      lit_count = 0;
      if (expected_records.size() > first_new) expected_records[$].eos = 1'b1;
    end
  endfunction

  // Offer one pixel, hold it until the transaction completes, then predict.
  task automatic offer_pixel(input logic [InW-1:0] px, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pixel_i      <= px;
    last_pixel_i <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    encode_pixel(px, last);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_pixel_format(input bit fmt);
    wait_idle();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= fmt;
    @(posedge clk_i);
    pix_fmt = fmt;
    cfg_wr_en_i <= 1'b0;
  endtask

  task automatic send_random_images(input int unsigned n_items);
    logic [InW-1:0] palette [4];
    logic [InW-1:0] jitter;
    logic [InW-1:0] px;
    int unsigned    sent;
    int unsigned    img_len;
    int unsigned    seg_len;
    int unsigned    k;
    int unsigned    j;
    bit             is_run;
    sent = 0;
    while (sent < n_items) begin
      foreach (palette[i]) palette[i] = InW'($urandom);
      // vary bits that the active pixel format drops
      jitter  = pix_fmt ? 24'h070307 : 24'hFF0000;
      img_len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      k = 0;
      while (k < img_len) begin
        seg_len = $urandom_range(1, 8);
        is_run  = $urandom_range(2) == 0;
        px      = palette[$urandom_range(3)];
        for (j = 0; j < seg_len && k < img_len; j++) begin
          if (!is_run) begin
            px = ($urandom_range(1) == 0) ? palette[$urandom_range(3)] : InW'($urandom);
          end
          offer_pixel(px ^ (InW'($urandom) & jitter), k == img_len - 1);
          k++;
          sent++;
        end
      end
    end
  endtask

  task automatic test_directed_rgb565();
    offer_pixel(24'hFFFFFF, 1'b1);
    offer_pixel(24'h000000, 1'b0);
    offer_pixel(24'h00FFFF, 1'b0);
    offer_pixel(24'h121234, 1'b0);
    offer_pixel(24'hAB1234, 1'b0);
    offer_pixel(24'h001234, 1'b0);
    offer_pixel(24'hFF1234, 1'b0);
    offer_pixel(24'h005555, 1'b0);
    offer_pixel(24'h005555, 1'b1);
    offer_pixel(24'h000007, 1'b0);
    offer_pixel(24'h000007, 1'b0);
    offer_pixel(24'h000007, 1'b1);
    offer_pixel(24'h000001, 1'b0);
    offer_pixel(24'h000002, 1'b0);
    offer_pixel(24'h000002, 1'b0);
    offer_pixel(24'h000003, 1'b1);
  endtask

  task automatic test_directed_bgr888();
    set_pixel_format(1'b1);
    offer_pixel(24'hFFFFFF, 1'b0);
    offer_pixel(24'h070307, 1'b0);
    offer_pixel(24'h000000, 1'b0);
    offer_pixel(24'h040004, 1'b0);
    offer_pixel(24'hF8FCF8, 1'b0);
    offer_pixel(24'hFFFFFF, 1'b1);
  endtask

  task automatic test_run_limit();
    int unsigned i;
    for (i = 0; i < 130; i++) offer_pixel(24'h5A5A5A, 1'b0);
    offer_pixel(24'hA5A5A5, 1'b0);
    offer_pixel(24'hA5A5A5, 1'b1);
  endtask

  task automatic test_literal_block_full();
    int unsigned i;
    set_pixel_format(1'b0);
    for (i = 0; i <= 130; i++) offer_pixel({8'($urandom), 16'(i * 3 + 1)}, i == 130);
  endtask

  task automatic test_receiver_holdoff();
    wait_idle();
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    send_random_images(20);
  endtask

  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall_i <= hold_start || (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    enc_record_t got;
    enc_record_t want;
    bit          bad;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{record_kind_o, header_byte_o, word_count_o, word_a_o, word_b_o, word_c_o,
              word_d_o, end_of_stream_o};
      if (expected_records.size() == 0) begin
        want = 'x;
        bad  = 1'b1;
      end else begin
        want = expected_records.pop_front();
        bad  = got !== want;
      end
      if (bad) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("record mismatch: expected kind=%0d hdr=%h cnt=%0d words=%h %h %h %h eos=%b",
                   want.kind, want.hdr, want.cnt, want.word_a, want.word_b, want.word_c,
                   want.word_d, want.eos);
          $display("                 actual   kind=%0d hdr=%h cnt=%0d words=%h %h %h %h eos=%b",
                   got.kind, got.hdr, got.cnt, got.word_a, got.word_b, got.word_c,
                   got.word_d, got.eos);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 35;
    recv_idle_pct = 79;
    test_directed_rgb565();
    test_directed_bgr888();
    test_run_limit();
    test_literal_block_full();
    send_random_images(10);

    send_idle_pct = 79;
    recv_idle_pct = 35;
    set_pixel_format(1'b1);
    send_random_images(10);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_receiver_holdoff();
    set_pixel_format(1'b0);
    send_random_images(5);

    in_valid_i <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_records.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
